// ===== src/est_pkg.sv =====
`timescale 1ns / 1ps
package est_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;

  localparam int unsigned ANG_W = 16;
  localparam int unsigned FAC_W = 16;
  localparam int unsigned TR_W  = 32;
  localparam int unsigned RES_W = 32;

  localparam int unsigned IN_DATA_W  = 6 * ANG_W + 3 * TR_W;
  localparam int unsigned OUT_DATA_W = 12 * RES_W;

  localparam int unsigned Q_FRAC = 30;
  localparam int unsigned ANG_SH = 18;
  localparam int unsigned ZW     = 36;
  localparam int unsigned XW     = 34;
  localparam int unsigned SC_W   = 32;
  localparam int unsigned ROT_W  = 34;
  localparam int unsigned NRM_SH = 6;
  localparam int unsigned MDL_SH = 22;
  localparam int unsigned DIV_NW = ROT_W - 1 - NRM_SH;
  localparam int unsigned DIV_DW = FAC_W;

  localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [XW-1:0] Q30_GAIN    = 34'sd652032874;

  typedef struct packed {
    logic signed [SC_W-1:0] s;
    logic signed [SC_W-1:0] c;
  } sc_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 36'sh03243F6A8;
      5'd1:  v = 36'sh01DAC6705;
      5'd2:  v = 36'sh00FADBAFC;
      5'd3:  v = 36'sh007F56EA6;
      5'd4:  v = 36'sh003FEAB76;
      5'd5:  v = 36'sh001FFD55B;
      5'd6:  v = 36'sh000FFFAAA;
      5'd7:  v = 36'sh0007FFF55;
      5'd8:  v = 36'sh0003FFFEA;
      5'd9:  v = 36'sh0001FFFFD;
      5'd10: v = 36'sh0000FFFFF;
      5'd11: v = 36'sh00007FFFF;
      5'd12: v = 36'sh00003FFFF;
      5'd13: v = 36'sh00001FFFF;
      5'd14: v = 36'sh00000FFFF;
      5'd15: v = 36'sh000007FFF;
      5'd16: v = 36'sh000003FFF;
      5'd17: v = 36'sh000001FFF;
      5'd18: v = 36'sh000000FFF;
      5'd19: v = 36'sh0000007FF;
      5'd20: v = 36'sh0000003FF;
      5'd21: v = 36'sh0000001FF;
      5'd22: v = 36'sh0000000FF;
      5'd23: v = 36'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/est_cordic.sv =====
`timescale 1ns / 1ps
module est_cordic import est_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] angle,
  output sc_t                     sc
);

  logic signed [ZW-1:0] z_ext;
  logic signed [ZW-1:0] zred_nxt, zred_r;
  logic signed [ZW-1:0] zf_nxt;
  logic                 neg_nxt;

  logic signed [XW-1:0] x_nxt [STAGES+1];
  logic signed [XW-1:0] y_nxt [STAGES+1];
  logic signed [ZW-1:0] z_nxt [STAGES+1];
  logic                 n_nxt [STAGES+1];
  logic signed [XW-1:0] x_r [STAGES+1];
  logic signed [XW-1:0] y_r [STAGES+1];
  logic signed [ZW-1:0] z_r [STAGES+1];
  logic                 n_r [STAGES+1];

  logic signed [XW-1:0] xo, yo;
  sc_t                  sc_nxt, sc_r;

  assign z_ext = {{(ZW-ANG_W-ANG_SH){angle[ANG_W-1]}}, angle, {ANG_SH{1'b0}}};

  always_comb begin
    zred_nxt = z_ext;
    if (z_ext > Q30_PI) begin
      zred_nxt = z_ext - Q30_TWO_PI;
    end else if (z_ext < -Q30_PI) begin
      zred_nxt = z_ext + Q30_TWO_PI;
    end
  end

  always_comb begin
    zf_nxt  = zred_r;
    neg_nxt = 1'b0;
    if (zred_r > Q30_HALF_PI) begin
      zf_nxt  = zred_r - Q30_PI;
      neg_nxt = 1'b1;
    end else if (zred_r < -Q30_HALF_PI) begin
      zf_nxt  = zred_r + Q30_PI;
      neg_nxt = 1'b1;
    end
  end

  always_comb begin
    x_nxt[0] = Q30_GAIN;
    y_nxt[0] = '0;
    z_nxt[0] = zf_nxt;
    n_nxt[0] = neg_nxt;
    for (int i = 0; i < STAGES; i++) begin
      n_nxt[i+1] = n_r[i];
      if (!z_r[i][ZW-1]) begin
        x_nxt[i+1] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] - atan_q30(5'(i));
      end else begin
        x_nxt[i+1] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] + atan_q30(5'(i));
      end
    end
  end

  always_comb begin
    xo = n_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
    yo = n_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];
    sc_nxt.c = xo[SC_W-1:0];
    sc_nxt.s = yo[SC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zred_r <= zred_nxt;
      for (int i = 0; i <= STAGES; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
        n_r[i] <= n_nxt[i];
      end
      sc_r <= sc_nxt;
    end
  end

  assign sc = sc_r;

endmodule

// ===== src/est_div.sv =====
`timescale 1ns / 1ps
module est_div import est_pkg::*; #(
  parameter int unsigned NW = DIV_NW,
  parameter int unsigned DW = DIV_DW,
  parameter int unsigned TW = ROT_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] tag_out
);

  logic [DW-1:0] rem_nxt [NW];
  logic [NW-1:0] num_nxt [NW];
  logic [DW-1:0] den_nxt [NW];
  logic [NW-1:0] q_nxt   [NW];
  logic [TW-1:0] tag_nxt [NW];
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [DW-1:0] den_r [NW];
  logic [NW-1:0] q_r   [NW];
  logic [TW-1:0] tag_r [NW];

  always_comb begin
    logic [DW-1:0] prem;
    logic [NW-1:0] pnum;
    logic [DW-1:0] pden;
    logic [NW-1:0] pq;
    logic [TW-1:0] ptag;
    logic [DW:0]   trial;
    for (int i = 0; i < NW; i++) begin
      if (i == 0) begin
        prem = '0;
        pnum = num;
        pden = den;
        pq   = '0;
        ptag = tag_in;
      end else begin
        prem = rem_r[i-1];
        pnum = num_r[i-1];
        pden = den_r[i-1];
        pq   = q_r[i-1];
        ptag = tag_r[i-1];
      end
      trial      = {prem, pnum[NW-1]};
      num_nxt[i] = pnum << 1;
      den_nxt[i] = pden;
      tag_nxt[i] = ptag;
      if (trial >= {1'b0, pden}) begin
        rem_nxt[i] = DW'(trial - {1'b0, pden});
        q_nxt[i]   = {pq[NW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[DW-1:0];
        q_nxt[i]   = {pq[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NW; i++) begin
        rem_r[i] <= rem_nxt[i];
        num_r[i] <= num_nxt[i];
        den_r[i] <= den_nxt[i];
        q_r[i]   <= q_nxt[i];
        tag_r[i] <= tag_nxt[i];
      end
    end
  end

  assign quo     = q_r[NW-1];
  assign tag_out = tag_r[NW-1];

endmodule

// ===== src/euler_scale_transform_matrix_core.sv =====
`timescale 1ns / 1ps
// Builds the 3x3 rotation-times-scale block and translation column of a model matrix from
// yaw/pitch/roll (applied Y, X, Z), per-axis Q8.8 scales and a Q16.16 translation; with
// in_tuser high it gives the normal matrix (columns divided by their scale, zero translation,
// a zero scale saturating its column). Fully pipelined: one item per cycle while in_tready is
// high. The path from accept to out_tvalid runs through the three CORDIC pipelines
// (CORDIC_STAGES + 3 stages) and the nine radix-2 divider lanes (27 stages). An output
// register plus one skid entry catch the item that leaves the pipeline as a stall begins;
// the pipeline then holds, and in_tready stays low, until the skid entry drains.
module euler_scale_transform_matrix_core import est_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pitch_angle, yaw_angle, roll_angle, factor_x, factor_y, factor_z,
  // translate_x, translate_y, translate_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z,
  // move_x, move_y, move_z
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned CL = CORDIC_STAGES + 3;
  localparam int unsigned DL = DIV_NW;
  localparam int unsigned SL = CL + DL + 5;
  localparam int unsigned MW = ROT_W + FAC_W;

  typedef struct packed {
    logic                        cmd;
    logic [2:0][FAC_W-1:0]       fac;
    logic [2:0][TR_W-1:0]        tr;
  } side_t;

  function automatic logic signed [SC_W-1:0] mul30(input logic signed [SC_W-1:0] a,
                                                   input logic signed [SC_W-1:0] b);
    logic signed [2*SC_W-1:0] p;
    p = a * b;
    return p[SC_W+Q_FRAC-1:Q_FRAC];
  endfunction

  logic en;
  logic skid_v_r, out_v_r;
  logic [OUT_DATA_W-1:0] skid_d_r, out_d_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  // side band and valid bits
  side_t side_in;
  side_t side_r [SL];
  logic  sv_r   [SL];

  assign side_in.cmd = in_tuser;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      side_in.fac[k] = in_tdata[(3+k)*ANG_W +: FAC_W];
      side_in.tr[k]  = in_tdata[6*ANG_W + k*TR_W +: TR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SL; i++) begin
        sv_r[i] <= 1'b0;
      end
    end else if (en) begin
      sv_r[0] <= in_tvalid;
      for (int i = 1; i < SL; i++) begin
        sv_r[i] <= sv_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < SL; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // sine / cosine
  sc_t sc_yaw, sc_pitch, sc_roll;

  est_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .angle(signed'(in_tdata[ANG_W +: ANG_W])), .sc(sc_yaw)
  );
  est_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .angle(signed'(in_tdata[0 +: ANG_W])), .sc(sc_pitch)
  );
  est_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .angle(signed'(in_tdata[2*ANG_W +: ANG_W])), .sc(sc_roll)
  );

  // first products
  logic signed [SC_W-1:0] s1s2_r, c1c3_r, c2s3_r, c1s2_r, c3s1_r;
  logic signed [SC_W-1:0] c1s3_r, c2c3_r, s1s3_r, c2s1_r, c1c2_r, s2a_r, s3a_r;
  // second products
  logic signed [SC_W-1:0] t0_r, t2_r, t3_r, t5_r;
  logic signed [SC_W-1:0] c1c3b_r, c2s3b_r, c3s1b_r, c1s3b_r, c2c3b_r;
  logic signed [SC_W-1:0] s1s3b_r, c2s1b_r, c1c2b_r, s2b_r;
  // rotation
  logic signed [ROT_W-1:0] rot_nxt [9];
  logic signed [ROT_W-1:0] rot_r   [9];
  // divider operands
  logic [DIV_NW-1:0]       num_r [9];
  logic [DIV_DW-1:0]       den_r [9];
  logic signed [ROT_W-1:0] rot4_r [9];
  logic [DIV_NW-1:0]       quo   [9];
  logic [ROT_W-1:0]        rotd  [9];
  // finish
  logic signed [MW-1:0]    mprod_r [9];
  logic signed [RES_W-1:0] nq_r    [9];
  logic                    rneg_r  [9];

  always_ff @(posedge clk) begin
    if (en) begin
      s1s2_r <= mul30(sc_yaw.s, sc_pitch.s);
      c1c3_r <= mul30(sc_yaw.c, sc_roll.c);
      c2s3_r <= mul30(sc_pitch.c, sc_roll.s);
      c1s2_r <= mul30(sc_yaw.c, sc_pitch.s);
      c3s1_r <= mul30(sc_roll.c, sc_yaw.s);
      c1s3_r <= mul30(sc_yaw.c, sc_roll.s);
      c2c3_r <= mul30(sc_pitch.c, sc_roll.c);
      s1s3_r <= mul30(sc_yaw.s, sc_roll.s);
      c2s1_r <= mul30(sc_pitch.c, sc_yaw.s);
      c1c2_r <= mul30(sc_yaw.c, sc_pitch.c);
      s2a_r  <= sc_pitch.s;
      s3a_r  <= sc_roll.s;

      t0_r    <= mul30(s1s2_r, s3a_r);
      t2_r    <= mul30(c1s2_r, s3a_r);
      t3_r    <= mul30(c3s1_r, s2a_r);
      t5_r    <= mul30(c1c3_r, s2a_r);
      c1c3b_r <= c1c3_r;
      c2s3b_r <= c2s3_r;
      c3s1b_r <= c3s1_r;
      c1s3b_r <= c1s3_r;
      c2c3b_r <= c2c3_r;
      s1s3b_r <= s1s3_r;
      c2s1b_r <= c2s1_r;
      c1c2b_r <= c1c2_r;
      s2b_r   <= s2a_r;
    end
  end

  always_comb begin
    rot_nxt[0] = ROT_W'(c1c3b_r) + ROT_W'(t0_r);
    rot_nxt[1] = ROT_W'(c2s3b_r);
    rot_nxt[2] = ROT_W'(t2_r) - ROT_W'(c3s1b_r);
    rot_nxt[3] = ROT_W'(t3_r) - ROT_W'(c1s3b_r);
    rot_nxt[4] = ROT_W'(c2c3b_r);
    rot_nxt[5] = ROT_W'(t5_r) + ROT_W'(s1s3b_r);
    rot_nxt[6] = ROT_W'(c2s1b_r);
    rot_nxt[7] = -ROT_W'(s2b_r);
    rot_nxt[8] = ROT_W'(c1c2b_r);
  end

  always_ff @(posedge clk) begin
    logic [ROT_W-1:0]        rabs;
    logic signed [FAC_W-1:0] f;
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        rot_r[k] <= rot_nxt[k];
        f    = signed'(side_r[CL+2].fac[k/3]);
        rabs = rot_r[k][ROT_W-1] ? ROT_W'(-rot_r[k]) : ROT_W'(rot_r[k]);
        num_r[k]  <= rabs[ROT_W-2:NRM_SH];
        den_r[k]  <= f[FAC_W-1] ? DIV_DW'(-f) : DIV_DW'(f);
        rot4_r[k] <= rot_r[k];
      end
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_div
    est_div #(.NW(DIV_NW), .DW(DIV_DW), .TW(ROT_W)) u_div (
      .clk(clk), .en(en), .num(num_r[k]), .den(den_r[k]),
      .tag_in(rot4_r[k]), .quo(quo[k]), .tag_out(rotd[k])
    );
  end

  always_ff @(posedge clk) begin
    logic signed [FAC_W-1:0] f;
    logic signed [ROT_W-1:0] r;
    logic signed [RES_W-1:0] qv;
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        f  = signed'(side_r[CL+3+DL].fac[k/3]);
        r  = signed'(rotd[k]);
        qv = signed'(RES_W'(quo[k]));
        mprod_r[k] <= r * f;
        nq_r[k]    <= (r[ROT_W-1] ^ f[FAC_W-1]) ? -qv : qv;
        rneg_r[k]  <= r[ROT_W-1];
      end
    end
  end

  // result selection
  logic [OUT_DATA_W-1:0] fin_d;
  logic                  fin_v;

  assign fin_v = sv_r[SL-1];

  always_comb begin
    logic signed [MW-MDL_SH-1:0] mres;
    logic                        nrm;
    logic                        fz;
    nrm   = side_r[SL-1].cmd;
    fin_d = '0;
    for (int k = 0; k < 9; k++) begin
      fz   = (side_r[SL-1].fac[k/3] == '0);
      mres = mprod_r[k][MW-1:MDL_SH];
      if (!nrm) begin
        fin_d[k*RES_W +: RES_W] = RES_W'(mres);
      end else if (fz) begin
        fin_d[k*RES_W +: RES_W] = rneg_r[k] ? {1'b1, {(RES_W-1){1'b0}}}
                                            : {1'b0, {(RES_W-1){1'b1}}};
      end else begin
        fin_d[k*RES_W +: RES_W] = nq_r[k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      fin_d[(9+k)*RES_W +: RES_W] = nrm ? '0 : side_r[SL-1].tr[k];
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      if (en && fin_v) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v_r && !out_tready) begin
      if (en && fin_v) begin
        skid_d_r <= fin_d;
      end
    end else if (skid_v_r) begin
      out_d_r <= skid_d_r;
    end else if (fin_v) begin
      out_d_r <= fin_d;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

// ===== src/est_checker.sv =====
`timescale 1ns / 1ps
module est_checker import est_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output item changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> out_tvalid)
    else $error("buffered item lost");

  a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && !in_tvalid |-> $past(out_tvalid))
    else $error("input stalled with empty output");

endmodule

bind euler_scale_transform_matrix_core est_checker u_est_checker (.*);
